// ===== hdl/blvm_pkg.sv =====
// types and constants shared by the battery low-voltage monitor
package blvm_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_VOLTAGE_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_VOLTAGE_OFFSET = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CELL_COUNT     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LOW_THR        = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_VERY_LOW_THR   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LOW_THR    = 3'd5;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned AdcW     = 12;
  localparam int unsigned GainW    = 16;
  localparam int unsigned CellW    = 4;
  localparam int unsigned ThrW     = 13;
  localparam int unsigned MvW      = 16;
  localparam int unsigned PackThrW = ThrW + CellW;
  localparam int unsigned AccW     = 20;
  localparam int unsigned SumW     = 25;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  // thresholds: low, very low, max low; max low also decides presence
  localparam int unsigned NumThr   = 3;
  localparam int unsigned MaxLevel = 4;
  localparam int unsigned LedLevel = 2;

  localparam logic [GainW-1:0] GAIN_RESET   = 16'd256;
  localparam logic [MvW-1:0]   OFFSET_RESET = 16'd0;
  localparam logic [CellW-1:0] CELLS_RESET  = 4'd3;
  localparam logic [ThrW-1:0]  LOW_RESET    = 13'd3500;
  localparam logic [ThrW-1:0]  VLOW_RESET   = 13'd3400;
  localparam logic [ThrW-1:0]  MLOW_RESET   = 13'd3300;

  // divide by 11: multiply by ceil(2^29 / 11), exact for sums below 2^25
  localparam int unsigned RecipW     = 26;
  localparam int unsigned RecipShift = 29;
  localparam logic [RecipW-1:0] RECIP_ELEVEN = 26'd48806447;
  localparam int unsigned QuoW = SumW + RecipW;

  localparam logic [3:0] LOW_BEEP_RATE  = 4'd10;
  localparam logic [5:0] VLOW_BEEP_RATE = 6'd50;

  typedef struct packed {
    logic load;
    logic mul;
    logic scale;
    logic filt;
    logic div;
    logic commit;
  } cmd_t;

endpackage

// ===== hdl/blvm_ctrl.sv =====
// sequencer for the monitor: input/output handshake and per-item step commands
module blvm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output blvm_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_FILT  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       commit;

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;
  // finished item goes out once the output register is free or being drained
  assign commit = (state_q == ST_DONE) && (!m_valid_q || m_ready_i);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.mul    = (state_q == ST_MUL);
    cmd_o.scale  = (state_q == ST_SCALE);
    cmd_o.filt   = (state_q == ST_FILT);
    cmd_o.div    = (state_q == ST_DIV);
    cmd_o.commit = commit;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_FILT;
      ST_FILT:  state_d = ST_DIV;
      ST_DIV:   state_d = ST_DONE;
      ST_DONE:  if (commit) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (commit) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

// ===== hdl/blvm_datapath.sv =====
// monitor datapath: config registers, scaling, filter, debounce and warning latches
module blvm_datapath #(
  parameter int unsigned NUM_LEVELS     = 3,
  parameter int unsigned DEBOUNCE_TICKS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  blvm_pkg::cmd_t                   cmd_i,
  input  logic                             cfg_we_i,
  input  logic [blvm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [blvm_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [blvm_pkg::InDataW-1:0]     in_data_i,
  output logic [blvm_pkg::OutDataW-1:0]    out_data_o
);

  localparam int unsigned CntW  = $clog2(DEBOUNCE_TICKS + 1);
  localparam int unsigned ProdW = blvm_pkg::AdcW + blvm_pkg::GainW;
  localparam logic [CntW-1:0] CntMax = CntW'(DEBOUNCE_TICKS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  // configuration
  logic [blvm_pkg::GainW-1:0] gain_q;
  logic [blvm_pkg::MvW-1:0]   offset_q;
  logic [blvm_pkg::CellW-1:0] cells_q;
  logic [blvm_pkg::ThrW-1:0]  thr_q [blvm_pkg::NumThr];

  // per-item payload
  logic [blvm_pkg::AdcW-1:0]     adc_q;
  logic                          armed_q;
  logic [ProdW-1:0]              prod_q;
  logic [blvm_pkg::MvW-1:0]      mv_q;
  logic [blvm_pkg::PackThrW-1:0] lim_q [blvm_pkg::NumThr];
  logic [blvm_pkg::SumW-1:0]     sum_q;
  logic [blvm_pkg::QuoW-1:0]     quo_q;
  logic [blvm_pkg::OutDataW-1:0] out_q;

  // monitor state
  logic                  conn_q;
  logic [blvm_pkg::AccW-1:0] acc_q;
  logic [CntW-1:0]       cnt_q [NUM_LEVELS];
  logic [CntW-1:0]       cnt_d [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] lat_q, lat_d, ev;
  logic                  last_armed_q;
  logic                  led_q, led_d;

  logic [blvm_pkg::CellW-1:0] cells;
  logic signed [21:0]         scaled;
  logic [blvm_pkg::MvW-1:0]   mv_clamp;
  logic [blvm_pkg::AccW-1:0]  seed;
  logic [blvm_pkg::AccW-1:0]  acc_new;
  logic                       disarm;
  logic                       led_ev;
  logic [blvm_pkg::MaxLevel-1:0] ev_ext, lat_ext;

  assign cells = (cells_q == '0) ? blvm_pkg::CellW'(1) : cells_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= blvm_pkg::GAIN_RESET;
      offset_q <= blvm_pkg::OFFSET_RESET;
      cells_q  <= blvm_pkg::CELLS_RESET;
      thr_q[0] <= blvm_pkg::LOW_RESET;
      thr_q[1] <= blvm_pkg::VLOW_RESET;
      thr_q[2] <= blvm_pkg::MLOW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        blvm_pkg::CFG_VOLTAGE_GAIN:   gain_q   <= cfg_data_i;
        blvm_pkg::CFG_VOLTAGE_OFFSET: offset_q <= cfg_data_i;
        blvm_pkg::CFG_CELL_COUNT:     cells_q  <= cfg_data_i[blvm_pkg::CellW-1:0];
        blvm_pkg::CFG_LOW_THR:        thr_q[0] <= cfg_data_i[blvm_pkg::ThrW-1:0];
        blvm_pkg::CFG_VERY_LOW_THR:   thr_q[1] <= cfg_data_i[blvm_pkg::ThrW-1:0];
        blvm_pkg::CFG_MAX_LOW_THR:    thr_q[2] <= cfg_data_i[blvm_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // floor(code * gain / 256) + offset, clamped to 0..65535
  assign scaled = $signed({2'b00, prod_q[ProdW-1:8]})
                + $signed({{6{offset_q[blvm_pkg::MvW-1]}}, offset_q});

  always_comb begin
    if (scaled[21]) begin
      mv_clamp = '0;
    end else if (scaled[20:16] != '0) begin
      mv_clamp = '1;
    end else begin
      mv_clamp = scaled[15:0];
    end
  end

  // first connected sample seeds the filter
  assign seed = conn_q ? acc_q : {mv_q, 4'b0000};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      adc_q   <= in_data_i[blvm_pkg::AdcW-1:0];
      armed_q <= in_data_i[blvm_pkg::AdcW];
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(adc_q) * ProdW'(gain_q);
    end
    if (cmd_i.scale) begin
      mv_q <= mv_clamp;
      for (int k = 0; k < blvm_pkg::NumThr; k++) begin
        lim_q[k] <= blvm_pkg::PackThrW'(thr_q[k]) * blvm_pkg::PackThrW'(cells);
      end
    end
    if (cmd_i.filt) begin
      sum_q <= blvm_pkg::SumW'({seed, 3'b000}) + blvm_pkg::SumW'({seed, 1'b0})
             + blvm_pkg::SumW'({mv_q, 4'b0000}) + blvm_pkg::SumW'(5);
    end
    if (cmd_i.div) begin
      quo_q <= blvm_pkg::QuoW'(sum_q) * blvm_pkg::QuoW'(blvm_pkg::RECIP_ELEVEN);
    end
    if (cmd_i.commit) begin
      out_q <= {6'b000000, led_d, lat_ext[2], lat_ext[1], lat_ext[0],
                lat_ext[1] ? blvm_pkg::VLOW_BEEP_RATE : 6'd0,
                lat_ext[0] ? blvm_pkg::LOW_BEEP_RATE : 4'd0,
                ev_ext[2], ev_ext[1], ev_ext[0], conn_q, acc_new[blvm_pkg::AccW-1:4]};
    end
  end

  assign acc_new = conn_q ? quo_q[blvm_pkg::RecipShift +: blvm_pkg::AccW] : acc_q;
  assign disarm  = !armed_q && last_armed_q;

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
    logic inc, dec;
    if (g < blvm_pkg::NumThr) begin : g_mon
      logic below;
      assign below = acc_new < {lim_q[g], 4'b0000};
      assign inc   = conn_q && below && (cnt_q[g] < CntMax);
      assign dec   = conn_q && !below && (cnt_q[g] != '0);
    end else begin : g_idle
      assign inc   = 1'b0;
      assign dec   = 1'b0;
    end
    assign cnt_d[g] = inc ? cnt_q[g] + CntOne : (dec ? cnt_q[g] - CntOne : cnt_q[g]);
    assign ev[g]    = inc && (cnt_q[g] + CntOne == CntMax) && !lat_q[g];
    assign lat_d[g] = !disarm && (lat_q[g] || ev[g]);
  end

  if (NUM_LEVELS > blvm_pkg::LedLevel) begin : g_led
    assign led_ev = ev[blvm_pkg::LedLevel];
  end else begin : g_no_led
    assign led_ev = 1'b0;
  end
  assign led_d = !disarm && (led_q || led_ev);

  for (genvar g = 0; g < blvm_pkg::MaxLevel; g++) begin : g_ext
    if (g < NUM_LEVELS) begin : g_on
      assign ev_ext[g]  = ev[g];
      assign lat_ext[g] = lat_d[g];
    end else begin : g_off
      assign ev_ext[g]  = 1'b0;
      assign lat_ext[g] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q       <= 1'b0;
      acc_q        <= '0;
      lat_q        <= '0;
      last_armed_q <= 1'b0;
      led_q        <= 1'b0;
      for (int k = 0; k < NUM_LEVELS; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      if (cmd_i.filt && ({1'b0, mv_q} > lim_q[blvm_pkg::NumThr-1])) begin
        conn_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        acc_q        <= acc_new;
        lat_q        <= lat_d;
        last_armed_q <= armed_q;
        led_q        <= led_d;
        for (int k = 0; k < NUM_LEVELS; k++) begin
          cnt_q[k] <= cnt_d[k];
        end
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/battery_low_voltage_monitor_unit.sv =====
// top level of the battery low-voltage monitor
//
//  channel  dir  handshake               payload
//  s_axis   in   s_axis_tvalid/tready    adc_code, armed
//  m_axis   out  m_axis_tvalid/tready    filtered mv, presence, events, beeps, latches, led
//  cfg      in   cfg_valid/cfg_ready     cfg_index, cfg_data (always ready)
//
// an item passes from acceptance to the output register through the
// step sequencer: gain multiply, offset/clamp, filter sum, divide-by-11
// multiply, debounce/latch update. the next item can be taken the cycle after
// the finished one is committed, so only one item is in flight at a time.
// reset clears filter, counters, latches and loads config defaults.
// a full output register holds the finished item in its last step.
module battery_low_voltage_monitor_unit #(
  parameter int unsigned NUM_LEVELS     = 3,
  parameter int unsigned DEBOUNCE_TICKS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [11:0] adc_code, [12] armed, [15:13] zero
  input  logic [blvm_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [15:0] filtered_pack_mv, [16] battery_connected, [17] low_event,
  // [18] very_low_event, [19] max_low_event, [23:20] low_beep_rate,
  // [29:24] very_low_beep_rate, [30] low_latched, [31] very_low_latched,
  // [32] max_low_latched, [33] led_on, [39:34] zero
  output logic [blvm_pkg::OutDataW-1:0] m_axis_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [blvm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [blvm_pkg::CfgDataW-1:0] cfg_data_i
);

  blvm_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  blvm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd)
  );

  blvm_datapath #(
    .NUM_LEVELS     (NUM_LEVELS),
    .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// ===== tb/battery_low_voltage_monitor_unit_test.sv =====
// self-checking testbench for the battery low-voltage monitor: tick streams vs a local predictor
module battery_low_voltage_monitor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEVELS   = 3;
  localparam int unsigned DEBOUNCE = 20;
  localparam int unsigned SETTLE   = 12;
  localparam logic [blvm_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [blvm_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  // one output item, msb first so it overlays m_axis_tdata_o directly
  typedef struct packed {
    logic [5:0]  pad;
    logic        led_on;
    logic        max_low_latched;
    logic        very_low_latched;
    logic        low_latched;
    logic [5:0]  very_low_beep;
    logic [3:0]  low_beep;
    logic        max_low_event;
    logic        very_low_event;
    logic        low_event;
    logic        connected;
    logic [15:0] pack_mv;
  } tick_result_t;

  typedef struct packed {
    logic                      connected;
    logic [blvm_pkg::AccW-1:0] acc;
    logic [2:0][4:0]           cnt;
    logic [2:0]                latch;
    logic                      last_armed;
    logic                      led;
  } mon_state_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [blvm_pkg::InDataW-1:0]  s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [blvm_pkg::OutDataW-1:0] m_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [blvm_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [blvm_pkg::CfgDataW-1:0] cfg_data = '0;

  // local copy of the register file and monitor state
  logic [blvm_pkg::GainW-1:0]      gain_r = blvm_pkg::GAIN_RESET;
  logic signed [blvm_pkg::MvW-1:0] offset_r = blvm_pkg::OFFSET_RESET;
  logic [blvm_pkg::CellW-1:0]      cells_r = blvm_pkg::CELLS_RESET;
  logic [2:0][blvm_pkg::ThrW-1:0]  thr_r = {blvm_pkg::MLOW_RESET, blvm_pkg::VLOW_RESET,
                                            blvm_pkg::LOW_RESET};
  mon_state_t                      mon_st = '0;

  tick_result_t expect_q[$];
  int unsigned  mismatch_count = 0;
  bit           tx_gaps_on = 1'b1;
  bit           rx_stalls_on = 1'b1;
  int           stall_left = 0;

  battery_low_voltage_monitor_unit #(
    .NUM_LEVELS    (LEVELS),
    .DEBOUNCE_TICKS(DEBOUNCE)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[battery_low_voltage_monitor_unit] ERROR");
    $finish;
  end

  function automatic int unsigned eff_cells();
    return (cells_r == 0) ? 1 : int'(cells_r);
  endfunction

  function automatic int unsigned scale_to_mv(input logic [blvm_pkg::AdcW-1:0] adc);
    longint unsigned prod;
    longint          mv;
    prod = longint'(adc) * longint'(gain_r);
    mv = longint'(prod >> 8) + longint'(offset_r);
    if (mv < 0) mv = 0;
    if (mv > 65535) mv = 65535;
    return int'(mv);
  endfunction

  // advances the monitor state by one tick and returns the output item
  function automatic tick_result_t predict_tick(inout mon_state_t st,
                                                input logic [blvm_pkg::AdcW-1:0] adc,
                                                input logic armed);
    int unsigned  cells;
    int unsigned  mv;
    int unsigned  acc;
    int unsigned  limit;
    logic [2:0]   ev;
    tick_result_t r;
    cells = eff_cells();
    mv = scale_to_mv(adc);
    ev = '0;
    acc = 32'(st.acc);
    if (!st.connected && mv > int'(thr_r[2]) * cells) begin
      st.connected = 1'b1;
      acc = mv << 4;
    end
    if (st.connected) begin
      acc = (10 * acc + (mv << 4) + 5) / 11;
      for (int i = 0; i < LEVELS && i < 3; i++) begin
        limit = (int'(thr_r[i]) * cells) << 4;
        if (acc < limit) begin
          if (st.cnt[i] < DEBOUNCE) begin
            st.cnt[i] = st.cnt[i] + 5'd1;
            if (st.cnt[i] == DEBOUNCE && !st.latch[i]) begin
              st.latch[i] = 1'b1;
              ev[i] = 1'b1;
              if (i == blvm_pkg::LedLevel) st.led = 1'b1;
            end
          end
        end else if (st.cnt[i] > 0) begin
          st.cnt[i] = st.cnt[i] - 5'd1;
        end
      end
    end
    st.acc = acc[blvm_pkg::AccW-1:0];
    // falling edge of armed drops every latch and the led
    if (!armed && st.last_armed) begin
      st.latch = '0;
      st.led = 1'b0;
    end
    st.last_armed = armed;

    r = '0;
    r.pack_mv = acc[blvm_pkg::AccW-1:4];
    r.connected = st.connected;
    r.low_event = ev[0];
    r.very_low_event = ev[1];
    r.max_low_event = ev[2];
    r.low_beep = st.latch[0] ? blvm_pkg::LOW_BEEP_RATE : 4'd0;
    r.very_low_beep = st.latch[1] ? blvm_pkg::VLOW_BEEP_RATE : 6'd0;
    r.low_latched = st.latch[0];
    r.very_low_latched = st.latch[1];
    r.max_low_latched = st.latch[2];
    r.led_on = st.led;
    return r;
  endfunction

  // rough inverse of the scaling, for aiming samples at a pack voltage
  function automatic int adc_for_mv(input int target);
    longint c;
    if (gain_r == 0) return int'($urandom_range(0, 4095));
    c = ((longint'(target) - longint'(offset_r)) * 256) / longint'(gain_r);
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return int'(c);
  endfunction

  function automatic int tx_gap();
    int unsigned r;
    if (!tx_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rx_stalls_on) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        m_tready <= 1'b1;
      end else if (r < 96) begin
        m_tready <= 1'b0;
        stall_left = int'($urandom_range(0, 3));
      end else begin
        m_tready <= 1'b0;
        stall_left = int'($urandom_range(10, 40));
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      tick_result_t want;
      tick_result_t got;
      got = m_tdata;
      if (expect_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item expected none got %h", $realtime, m_tdata);
      end else begin
        want = expect_q.pop_front();
        check_field("filtered_pack_mv", want.pack_mv, got.pack_mv);
        check_field("battery_connected", 16'(want.connected), 16'(got.connected));
        check_field("low_event", 16'(want.low_event), 16'(got.low_event));
        check_field("very_low_event", 16'(want.very_low_event), 16'(got.very_low_event));
        check_field("max_low_event", 16'(want.max_low_event), 16'(got.max_low_event));
        check_field("low_beep_rate", 16'(want.low_beep), 16'(got.low_beep));
        check_field("very_low_beep_rate", 16'(want.very_low_beep), 16'(got.very_low_beep));
        check_field("low_latched", 16'(want.low_latched), 16'(got.low_latched));
        check_field("very_low_latched", 16'(want.very_low_latched),
                    16'(got.very_low_latched));
        check_field("max_low_latched", 16'(want.max_low_latched), 16'(got.max_low_latched));
        check_field("led_on", 16'(want.led_on), 16'(got.led_on));
        check_field("padding", 16'(want.pad), 16'(got.pad));
      end
    end
  end

  task automatic send_tick(input logic [blvm_pkg::AdcW-1:0] adc, input logic armed);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, armed, adc};
    do @(posedge clk); while (!s_tready);
    expect_q.push_back(predict_tick(mon_st, adc, armed));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [blvm_pkg::CfgIdxW-1:0] idx,
                           input logic [blvm_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      blvm_pkg::CFG_VOLTAGE_GAIN:   gain_r = data;
      blvm_pkg::CFG_VOLTAGE_OFFSET: offset_r = data;
      blvm_pkg::CFG_CELL_COUNT:     cells_r = data[blvm_pkg::CellW-1:0];
      blvm_pkg::CFG_LOW_THR:        thr_r[0] = data[blvm_pkg::ThrW-1:0];
      blvm_pkg::CFG_VERY_LOW_THR:   thr_r[1] = data[blvm_pkg::ThrW-1:0];
      blvm_pkg::CFG_MAX_LOW_THR:    thr_r[2] = data[blvm_pkg::ThrW-1:0];
      default: ;
    endcase
  endtask

  // narrow registers get junk in their unused upper bits
  task automatic program_regs(input logic [15:0] gain, input logic [15:0] offset,
                              input logic [3:0] cells, input logic [12:0] t_low,
                              input logic [12:0] t_vlow, input logic [12:0] t_mlow);
    logic [15:0] junk;
    wait_idle();
    junk = 16'($urandom);
    write_reg(blvm_pkg::CFG_VOLTAGE_GAIN, gain);
    write_reg(blvm_pkg::CFG_VOLTAGE_OFFSET, offset);
    write_reg(blvm_pkg::CFG_CELL_COUNT, {junk[15:4], cells});
    write_reg(blvm_pkg::CFG_LOW_THR, {junk[2:0], t_low});
    write_reg(blvm_pkg::CFG_VERY_LOW_THR, {junk[5:3], t_vlow});
    write_reg(blvm_pkg::CFG_MAX_LOW_THR, {junk[8:6], t_mlow});
    write_reg(CFG_SPARE_LO, 16'($urandom));
    write_reg(CFG_SPARE_HI, 16'($urandom));
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // default scaling can never reach the presence threshold: filter must hold at zero
  task automatic test_unconnected_hold();
    send_tick(12'd0, 1'b0);
    send_tick(12'hFFF, 1'b1);
    send_tick(12'hAAA, 1'b1);
    send_tick(12'h555, 1'b0);
    send_tick(12'hFFF, 1'b0);
    send_tick(12'd0, 1'b1);
    send_tick(12'd0, 1'b0);
  endtask

  task automatic test_first_connect();
    program_regs(16'd800, 16'd0, 4'd3, 13'd3500, 13'd3400, 13'd3300);
    send_tick(12'hFFF, 1'b1);
    send_tick(12'd0, 1'b1);
    send_tick(12'hFFF, 1'b1);
    send_tick(12'd3200, 1'b1);
    send_tick(12'd3100, 1'b0);
    send_tick(12'd3000, 1'b1);
  endtask

  // clamp at both ends, zero cells read as one
  task automatic test_scaling_extremes();
    program_regs(16'hFFFF, 16'h8000, 4'd0, 13'd0, 13'h1FFF, 13'h1555);
    send_tick(12'd0, 1'b1);
    send_tick(12'd128, 1'b1);
    send_tick(12'd129, 1'b1);
    send_tick(12'hFFF, 1'b1);
    send_tick(12'hFFF, 1'b0);
    send_tick(12'h800, 1'b1);
  endtask

  // armed flights that sag toward a threshold, with bursts of noise between
  task automatic run_flight(input int n_items);
    int           sent;
    int           kind;
    int           lvl;
    int           hold;
    int           target;
    int           code;
    logic         armed_now;
    mon_state_t   probe;
    tick_result_t peek;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      tx_gaps_on = ($urandom_range(0, 4) != 0);
      rx_stalls_on = ($urandom_range(0, 4) != 0);
      if (kind == 0) begin
        hold = $urandom_range(1, 6);
        for (int k = 0; k < hold; k++) begin
          send_tick(blvm_pkg::AdcW'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end else begin
        lvl = $urandom_range(0, 3);
        if (lvl == 3) target = int'(thr_r[0]) * int'(eff_cells()) + int'($urandom_range(0, 800));
        else target = int'(thr_r[lvl]) * int'(eff_cells()) - int'($urandom_range(0, 400));
        hold = $urandom_range(5, 45);
        for (int k = 0; k < hold; k++) begin
          code = adc_for_mv(target) + int'($urandom_range(0, 16)) - 8;
          if (code < 0) code = 0;
          if (code > 4095) code = 4095;
          armed_now = 1'b1;
          // sometimes disarm exactly on the tick that latches a warning
          probe = mon_st;
          peek = predict_tick(probe, blvm_pkg::AdcW'(code), 1'b1);
          if ((peek.low_event || peek.very_low_event || peek.max_low_event) &&
              $urandom_range(0, 2) == 0) armed_now = 1'b0;
          send_tick(blvm_pkg::AdcW'(code), armed_now);
          sent++;
        end
        if ($urandom_range(0, 2) == 0) begin
          hold = $urandom_range(1, 3);
          for (int k = 0; k < hold; k++) begin
            send_tick(blvm_pkg::AdcW'(adc_for_mv(target)), 1'b0);
            sent++;
          end
        end
      end
      if ($urandom_range(0, 14) == 0) wait_idle();
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_flight_profiles();
    int unsigned base;
    program_regs(16'd800, 16'd0, 4'd3, 13'd3500, 13'd3400, 13'd3300);
    run_flight(600);
    program_regs(16'hFFFF, 16'h8000, 4'd8, 13'd4000, 13'd3800, 13'd3600);
    run_flight(250);
    // thresholds beyond reach: always below
    program_regs(16'd2000, 16'h7FFF, 4'd15, 13'h1FFF, 13'h1FFF, 13'h1FFF);
    run_flight(150);
    // zero gain, zero thresholds: constant pack, never below
    program_regs(16'd0, 16'd1000, 4'd0, 13'd0, 13'd0, 13'd0);
    run_flight(100);
    repeat (3) begin
      base = $urandom_range(2800, 4200);
      program_regs(16'($urandom_range(300, 1500)), 16'($urandom_range(0, 2000) - 1000),
                   4'($urandom_range(1, 8)), 13'(base + $urandom_range(0, 300)), 13'(base),
                   13'(base - $urandom_range(0, 300)));
      run_flight(230);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unconnected_hold();
    test_first_connect();
    test_scaling_extremes();
    test_flight_profiles();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("[battery_low_voltage_monitor_unit] OK");
    end else begin
      $display("[battery_low_voltage_monitor_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/blvm_pkg.sv
hdl/blvm_ctrl.sv
hdl/blvm_datapath.sv
hdl/battery_low_voltage_monitor_unit.sv
tb/battery_low_voltage_monitor_unit_test.sv
